// ===== hdl/stat_pkg.sv =====
package stat_pkg;

    // Table geometry
    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int LIM_W       = $clog2(MAX_ENTRIES + 1);

    // Field widths
    localparam int ADDR_W      = 64;
    localparam int ENTRY_IDX_W = 4;
    localparam int CNT_W       = 5;

    // Configuration port
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = CNT_W;

    localparam logic [CFG_IDX_W-1:0] REG_TRANSLATE_ENABLE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT      = 1'd1;

    // Command codes
    localparam logic CMD_TRANSLATE = 1'b0;
    localparam logic CMD_WRITE     = 1'b1;

    typedef struct packed {
        logic [ADDR_W-1:0] virt;
        logic [ADDR_W-1:0] phys;
        logic [ADDR_W-1:0] len;
    } entry_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        entry_t           data;
    } ram_wr_t;

    typedef struct packed {
        logic             translate_enable;
        logic [CNT_W-1:0] entry_count;
    } cfg_t;

endpackage

// ===== hdl/stat_table_ram.sv =====
module stat_table_ram import stat_pkg::*; (
    input  logic             aclk,
    input  ram_wr_t          wr,
    input  logic [IDX_W-1:0] rd_addr,
    output entry_t           rd_data
);

    entry_t mem [MAX_ENTRIES];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/stat_scan_ctrl.sv =====
module stat_scan_ctrl import stat_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  cfg_t                   cfg,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_cmd,
    input  logic [ADDR_W-1:0]      s_address,
    input  logic [ENTRY_IDX_W-1:0] s_entry_index,
    input  logic [ADDR_W-1:0]      s_entry_virtual,
    input  logic [ADDR_W-1:0]      s_entry_physical,
    input  logic [ADDR_W-1:0]      s_entry_size,
    output ram_wr_t                ram_wr,
    output logic [IDX_W-1:0]       ram_rd_addr,
    input  entry_t                 ram_rd_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [ADDR_W-1:0]      m_physical_address,
    output logic                   m_fault
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ADD,
        ST_DONE
    } state_t;

    state_t            state_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [LIM_W-1:0]  limit_reg;
    logic [LIM_W-1:0]  issue_idx_reg;
    logic              data_valid_reg;
    logic              data_last_reg;
    logic [ADDR_W-1:0] hit_off_reg;
    logic [ADDR_W-1:0] hit_phys_reg;
    logic [ADDR_W-1:0] res_phys_reg;
    logic              res_fault_reg;
    logic              m_valid_reg;
    logic [ADDR_W-1:0] m_phys_reg;
    logic              m_fault_reg;

    logic              accept;
    logic [LIM_W-1:0]  cfg_limit;
    logic [LIM_W-1:0]  issue_idx_inc;
    logic              issue_more;
    logic [ADDR_W-1:0] scan_off;
    logic              scan_hit;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // entry_count above the table depth scans the whole table
    assign cfg_limit = (32'(cfg.entry_count) > MAX_ENTRIES) ? LIM_W'(MAX_ENTRIES)
                                                            : LIM_W'(cfg.entry_count);

    assign ram_wr.en        = accept && (s_cmd == CMD_WRITE)
                              && (32'(s_entry_index) < MAX_ENTRIES);
    assign ram_wr.addr      = IDX_W'(s_entry_index);
    assign ram_wr.data.virt = s_entry_virtual;
    assign ram_wr.data.phys = s_entry_physical;
    assign ram_wr.data.len  = s_entry_size;

    // entry 0 is read on the accepting edge
    assign ram_rd_addr = (state_reg == ST_IDLE) ? '0 : issue_idx_reg[IDX_W-1:0];

    assign issue_idx_inc = LIM_W'(issue_idx_reg + 1'b1);
    assign issue_more    = (issue_idx_reg < limit_reg);

    // wrapping range test: (addr - start) mod 2^64 < length
    assign scan_off = addr_reg - ram_rd_data.virt;
    assign scan_hit = data_valid_reg && (scan_off < ram_rd_data.len);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            data_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            // ST_DONE handles the output register itself
            if (m_valid_reg && m_ready && (state_reg != ST_DONE)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept && (s_cmd == CMD_TRANSLATE)) begin
                        addr_reg       <= s_address;
                        limit_reg      <= cfg_limit;
                        issue_idx_reg  <= LIM_W'(1);
                        data_last_reg  <= (cfg_limit == LIM_W'(1));
                        priority if (!cfg.translate_enable) begin
                            res_phys_reg  <= s_address;
                            res_fault_reg <= 1'b0;
                            state_reg     <= ST_DONE;
                        end else if (cfg_limit == '0) begin
                            res_phys_reg  <= '0;
                            res_fault_reg <= 1'b1;
                            state_reg     <= ST_DONE;
                        end else begin
                            data_valid_reg <= 1'b1;
                            state_reg      <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    priority if (scan_hit) begin
                        hit_off_reg    <= scan_off;
                        hit_phys_reg   <= ram_rd_data.phys;
                        data_valid_reg <= 1'b0;
                        state_reg      <= ST_ADD;
                    end else if (data_valid_reg && data_last_reg) begin
                        res_phys_reg   <= '0;
                        res_fault_reg  <= 1'b1;
                        data_valid_reg <= 1'b0;
                        state_reg      <= ST_DONE;
                    end else begin
                        data_valid_reg <= issue_more;
                        data_last_reg  <= (issue_idx_inc == limit_reg);
                        if (issue_more) begin
                            issue_idx_reg <= issue_idx_inc;
                        end
                    end
                end
                ST_ADD: begin
                    res_phys_reg  <= hit_phys_reg + hit_off_reg;
                    res_fault_reg <= 1'b0;
                    state_reg     <= ST_DONE;
                end
                ST_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_phys_reg  <= res_phys_reg;
                        m_fault_reg <= res_fault_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_physical_address = m_phys_reg;
    assign m_fault            = m_fault_reg;

endmodule

// ===== hdl/segment_table_address_translator.sv =====
// Segment table address translator. A table of 16 entries (virtual start,
// physical start, length) sits in one synchronous RAM with a registered read.
// A write transfer (s_cmd = 1) stores one entry, gives no result. A translate
// transfer (s_cmd = 0) gives exactly one result. With translate_enable clear
// the address comes back unchanged. Otherwise entries 0 .. entry_count-1 (all
// 16 when entry_count is larger) are read one per cycle, and the range test
// (address - start, mod 2^64, below length) runs on each read word; the lowest
// matching entry wins and gives physical start plus offset, else the result
// is zero with m_fault set. The single RAM read port, one entry per cycle,
// sets how long a scan runs: it ends at the first hit or after the last entry
// in range. Input is taken one item at a time, but a new item is taken while
// the previous result still waits in the output register. Entries read by a
// scan must have been written first. Config writes on the cfg_* port take
// effect at once and belong only to idle periods.
module segment_table_address_translator import stat_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    // configuration
    input  logic                   cfg_write_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    // request channel
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_cmd,
    input  logic [ADDR_W-1:0]      s_address,
    input  logic [ENTRY_IDX_W-1:0] s_entry_index,
    input  logic [ADDR_W-1:0]      s_entry_virtual,
    input  logic [ADDR_W-1:0]      s_entry_physical,
    input  logic [ADDR_W-1:0]      s_entry_size,
    // result channel
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [ADDR_W-1:0]      m_physical_address,
    output logic                   m_fault
);

    cfg_t             cfg_reg;
    ram_wr_t          ram_wr;
    logic [IDX_W-1:0] ram_rd_addr;
    entry_t           ram_rd_data;

    // Config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.translate_enable <= 1'b0;
            cfg_reg.entry_count      <= '0;
        end else if (cfg_write_en) begin
            unique case (cfg_index)
                REG_TRANSLATE_ENABLE: cfg_reg.translate_enable <= cfg_wdata[0];
                REG_ENTRY_COUNT:      cfg_reg.entry_count      <= cfg_wdata[CNT_W-1:0];
            endcase
        end
    end

    // Scan sequencer: entry writes, read issue, range compare, result register
    stat_scan_ctrl u_ctrl (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg                (cfg_reg),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_cmd              (s_cmd),
        .s_address          (s_address),
        .s_entry_index      (s_entry_index),
        .s_entry_virtual    (s_entry_virtual),
        .s_entry_physical   (s_entry_physical),
        .s_entry_size       (s_entry_size),
        .ram_wr             (ram_wr),
        .ram_rd_addr        (ram_rd_addr),
        .ram_rd_data        (ram_rd_data),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_physical_address (m_physical_address),
        .m_fault            (m_fault)
    );

    // Segment table storage, registered read
    stat_table_ram u_table (
        .aclk    (aclk),
        .wr      (ram_wr),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

endmodule

// ===== hdl/stat_checker.sv =====
module stat_checker import stat_pkg::*; (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_valid,
    input logic                   s_ready,
    input logic                   s_cmd,
    input logic                   m_valid,
    input logic                   m_ready,
    input logic [ADDR_W-1:0]      m_physical_address,
    input logic                   m_fault
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_physical_address) && $stable(m_fault))
        else $error("result changed while stalled");

    // a fault always carries a zero address
    a_fault_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_fault |-> m_physical_address == '0)
        else $error("fault with nonzero address");

    // a table write never produces a result
    a_write_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_cmd == CMD_WRITE)
        |=> !m_valid || ($past(m_valid) && !$past(m_ready)))
        else $error("result after table write");

    // one translation at a time
    a_translate_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_cmd == CMD_TRANSLATE) |=> !s_ready)
        else $error("request taken during translation");

endmodule

bind segment_table_address_translator stat_checker u_checker (.*);

// ===== dv/segment_table_address_translator_tb.sv =====
`timescale 1ns / 1ps

// Segment table translator bench.
// A short directed table comes first: pass-through after reset, a hand-built table
// with wrap, overlap and zero-length entries, and count zero. A random part
// follows. Writes and translates are mixed, and translate addresses are aimed at
// entry edges and interiors, at a dense cluster of overlapping ranges, or anywhere.
// Each translate transfer is checked, in order and field by field, against a
// hand-written result or a local model of the table.
module segment_table_address_translator_tb;
    import stat_pkg::*;

    // Idle headroom after the last result, before reg writes.
    localparam int SETTLE_CYCLES    = 24;
    localparam int CYCLE_LIMIT      = 400000;
    localparam int PHASES           = 12;
    localparam int ITEMS_PER_PHASE  = 126;
    localparam int MAX_REPORTS      = 10;
    // Entries placed here overlap often, so lowest-index priority gets exercised.
    localparam logic [ADDR_W-1:0] CLUSTER_BASE = 64'h0000_4000_0000_0000;

    typedef struct packed {
        logic [ADDR_W-1:0] phys;
        logic              fault;
    } xlate_t;

    // One stimulus row: either a request transfer or a register setting.
    typedef struct packed {
        logic                   setup;
        logic                   cmd;
        logic [ADDR_W-1:0]      address;
        logic [ENTRY_IDX_W-1:0] idx;
        entry_t                 ent;
        logic                   typed;      // want holds a hand-written result
        xlate_t                 want;
        logic                   cfg_en;
        logic [CNT_W-1:0]       cfg_cnt;
    } stim_row_t;

    // DUT ports
    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   cfg_write_en;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    logic                   s_valid;
    logic                   s_ready;
    logic                   s_cmd;
    logic [ADDR_W-1:0]      s_address;
    logic [ENTRY_IDX_W-1:0] s_entry_index;
    logic [ADDR_W-1:0]      s_entry_virtual;
    logic [ADDR_W-1:0]      s_entry_physical;
    logic [ADDR_W-1:0]      s_entry_size;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [ADDR_W-1:0]      m_physical_address;
    logic                   m_fault;

    // Local copy of the table and the registers
    entry_t           seg_tbl [MAX_ENTRIES];
    logic             seg_written [MAX_ENTRIES];
    logic             cfg_en;
    logic [CNT_W-1:0] cfg_count;

    xlate_t    xlate_expect_q [$];
    stim_row_t directed_rows [$];

    int snd_idle_pct = 34;
    int rcv_idle_pct = 75;
    int unsigned cycle_cnt = 0;
    int n_mismatch = 0;
    int n_checked  = 0;
    int n_faulted  = 0;
    int n_xlates   = 0;
    int n_writes   = 0;
    int n_settings = 0;

    segment_table_address_translator uut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_write_en       (cfg_write_en),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_cmd              (s_cmd),
        .s_address          (s_address),
        .s_entry_index      (s_entry_index),
        .s_entry_virtual    (s_entry_virtual),
        .s_entry_physical   (s_entry_physical),
        .s_entry_size       (s_entry_size),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_physical_address (m_physical_address),
        .m_fault            (m_fault)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, xlate_expect_q.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Result side backpressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    function automatic logic [ADDR_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // First entry in use whose range holds the address wins; offset taken mod 2^64,
    // so ranges past the top wrap to zero and a zero length never hits.
    function automatic xlate_t predict_translation(input logic [ADDR_W-1:0] a);
        xlate_t           r;
        int               lim;
        logic [ADDR_W-1:0] off;
        r.phys  = a;
        r.fault = 1'b0;
        if (!cfg_en)
            return r;
        lim = (cfg_count > MAX_ENTRIES) ? MAX_ENTRIES : int'(cfg_count);
        for (int k = 0; k < lim; k++) begin
            off = a - seg_tbl[k].virt;
            if (off < seg_tbl[k].len) begin
                r.phys = seg_tbl[k].phys + off;
                return r;
            end
        end
        r.phys  = '0;
        r.fault = 1'b1;
        return r;
    endfunction

    function automatic entry_t rand_entry();
        entry_t e;
        int     sel;
        e.virt = ($urandom_range(1)) ? CLUSTER_BASE + $urandom_range(0, 65535) : rand64();
        e.phys = rand64();
        sel = $urandom_range(99);
        if (sel < 5)
            e.len = '0;
        else if (sel < 55)
            e.len = ADDR_W'($urandom_range(1, 4096));
        else if (sel < 75)
            e.len = {32'h0, $urandom};
        else if (sel < 85)
            e.len = rand64();
        else if (sel < 90)
            e.len = '1;
        else begin
            // range that runs over the top of the address space
            e.virt = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 4095);
            e.len  = ADDR_W'($urandom_range(4097, 16384));
        end
        return e;
    endfunction

    // Aim at the edges and interior of an entry in use, at the cluster, or anywhere at all.
    function automatic logic [ADDR_W-1:0] pick_address();
        int     lim;
        int     sel;
        entry_t e;
        lim = (cfg_count > MAX_ENTRIES) ? MAX_ENTRIES : int'(cfg_count);
        if (lim == 0)
            lim = MAX_ENTRIES;
        e   = seg_tbl[IDX_W'($urandom_range(0, lim - 1))];
        sel = $urandom_range(99);
        if (sel < 15)
            return rand64();
        else if (sel < 25)
            return CLUSTER_BASE + $urandom_range(0, 65535 + 4096);
        else if (sel < 35)
            return e.virt - 1;
        else if (sel < 45)
            return e.virt + e.len;
        else if (sel < 55)
            return e.virt + e.len - 1;
        else if (sel < 65)
            return e.virt;
        else if (e.len == '0)
            return e.virt;
        else
            return e.virt + (rand64() % e.len);
    endfunction

    function automatic stim_row_t row_xlate(input logic [ADDR_W-1:0] a, input logic typed,
                                            input logic [ADDR_W-1:0] phys, input logic fault);
        stim_row_t r;
        r            = '0;
        r.cmd        = CMD_TRANSLATE;
        r.address    = a;
        r.typed      = typed;
        r.want.phys  = phys;
        r.want.fault = fault;
        return r;
    endfunction

    function automatic stim_row_t row_write(input logic [ENTRY_IDX_W-1:0] idx,
                                            input logic [ADDR_W-1:0] v,
                                            input logic [ADDR_W-1:0] p,
                                            input logic [ADDR_W-1:0] len);
        stim_row_t r;
        r          = '0;
        r.cmd      = CMD_WRITE;
        r.idx      = idx;
        r.ent.virt = v;
        r.ent.phys = p;
        r.ent.len  = len;
        return r;
    endfunction

    function automatic stim_row_t row_setup(input logic en, input logic [CNT_W-1:0] cnt);
        stim_row_t r;
        r         = '0;
        r.setup   = 1'b1;
        r.cfg_en  = en;
        r.cfg_cnt = cnt;
        return r;
    endfunction

    function automatic stim_row_t random_row();
        stim_row_t r;
        r         = '0;
        r.idx     = ENTRY_IDX_W'($urandom_range(0, MAX_ENTRIES - 1));
        r.ent     = rand_entry();
        if ($urandom_range(99) < 15) begin
            r.cmd     = CMD_WRITE;
            r.address = rand64();
        end else begin
            r.cmd     = CMD_TRANSLATE;
            r.address = pick_address();
        end
        return r;
    endfunction

    // One request transfer; bookkeeping happens at the accepting edge.
    task automatic issue(input stim_row_t r);
        xlate_t w;
        while (snd_idle_pct != 0 && $urandom_range(99) < snd_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_cmd            <= r.cmd;
        s_address        <= r.address;
        s_entry_index    <= r.idx;
        s_entry_virtual  <= r.ent.virt;
        s_entry_physical <= r.ent.phys;
        s_entry_size     <= r.ent.len;
        do @(posedge aclk); while (!s_ready);
        if (r.cmd == CMD_WRITE) begin
            seg_tbl[r.idx]     = r.ent;
            seg_written[r.idx] = 1'b1;
            n_writes++;
        end else begin
            w = r.typed ? r.want : predict_translation(r.address);
            xlate_expect_q.push_back(w);
            n_xlates++;
        end
    endtask

    // Drop valid, wait for every outstanding result, then let a trailing write land.
    task automatic settle();
        s_valid <= 1'b0;
        while (xlate_expect_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic program_regs(input logic en, input logic [CNT_W-1:0] cnt);
        cfg_write_en <= 1'b1;
        cfg_index    <= REG_TRANSLATE_ENABLE;
        cfg_wdata    <= CFG_DATA_W'(en);
        @(posedge aclk);
        cfg_index    <= REG_ENTRY_COUNT;
        cfg_wdata    <= cnt;
        @(posedge aclk);
        cfg_write_en <= 1'b0;
        cfg_en    = en;
        cfg_count = cnt;
        n_settings++;
    endtask

    // Result checker: in-order compare against the oldest expectation.
    xlate_t mon_want;
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (xlate_expect_q.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= MAX_REPORTS)
                    $display("%0t: unexpected result phys=%h fault=%b",
                             $realtime, m_physical_address, m_fault);
            end else begin
                mon_want = xlate_expect_q.pop_front();
                n_checked++;
                if (mon_want.fault)
                    n_faulted++;
                if (m_physical_address !== mon_want.phys || m_fault !== mon_want.fault) begin
                    n_mismatch++;
                    if (n_mismatch <= MAX_REPORTS)
                        $display("%0t: result %0d expected phys=%h fault=%b, got phys=%h fault=%b",
                                 $realtime, n_checked, mon_want.phys, mon_want.fault,
                                 m_physical_address, m_fault);
                end
            end
        end
    end

    initial begin
        logic [CNT_W-1:0] cnt;
        entry_t           fill_ent;

        aresetn          <= 1'b0;
        cfg_write_en     <= 1'b0;
        cfg_index        <= REG_TRANSLATE_ENABLE;
        cfg_wdata        <= '0;
        s_valid          <= 1'b0;
        s_cmd            <= CMD_TRANSLATE;
        s_address        <= '0;
        s_entry_index    <= '0;
        s_entry_virtual  <= '0;
        s_entry_physical <= '0;
        s_entry_size     <= '0;
        cfg_en    = 1'b0;
        cfg_count = '0;
        for (int k = 0; k < MAX_ENTRIES; k++) begin
            seg_tbl[k]     = '0;
            seg_written[k] = 1'b0;
        end

        // Directed table. Reset state: translation off, count zero.
        directed_rows.push_back(row_xlate(64'h0, 1'b1, 64'h0, 1'b0));
        directed_rows.push_back(row_xlate('1, 1'b1, '1, 1'b0));
        // physical start near the top, so the sum wraps
        directed_rows.push_back(row_write(4'd0, 64'h1000, 64'hFFFF_FFFF_FFFF_F800, 64'h1000));
        // range running past the top of the address space
        directed_rows.push_back(row_write(4'd1, 64'hFFFF_FFFF_FFFF_FF00, 64'h2000, 64'h200));
        // overlaps entry 0; entry 0 must win
        directed_rows.push_back(row_write(4'd2, 64'h1800, 64'h9000, 64'h100));
        // zero length
        directed_rows.push_back(row_write(4'd3, 64'h5000, 64'h7000, 64'h0));
        directed_rows.push_back(row_write(4'd15, '1, 64'h0, '1));
        // enabled with no entries in use: everything faults
        directed_rows.push_back(row_setup(1'b1, 5'd0));
        directed_rows.push_back(row_xlate(64'h1000, 1'b1, 64'h0, 1'b1));
        directed_rows.push_back(row_setup(1'b1, 5'd4));
        directed_rows.push_back(row_xlate(64'h1000, 1'b0, '0, 1'b0));
        directed_rows.push_back(row_xlate(64'h1FFF, 1'b0, '0, 1'b0));
        directed_rows.push_back(row_xlate(64'h2000, 1'b1, 64'h0, 1'b1));
        directed_rows.push_back(row_xlate(64'h1800, 1'b0, '0, 1'b0));
        directed_rows.push_back(row_xlate('1, 1'b0, '0, 1'b0));
        directed_rows.push_back(row_xlate(64'h0, 1'b0, '0, 1'b0));
        directed_rows.push_back(row_xlate(64'h100, 1'b1, 64'h0, 1'b1));
        directed_rows.push_back(row_xlate(64'h5000, 1'b1, 64'h0, 1'b1));
        directed_rows.push_back(row_xlate(64'h0FFF, 1'b1, 64'h0, 1'b1));
        // table loaded but translation off: pass-through
        directed_rows.push_back(row_setup(1'b0, 5'd4));
        directed_rows.push_back(row_xlate(64'h2000, 1'b1, 64'h2000, 1'b0));

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].setup) begin
                settle();
                program_regs(directed_rows[i].cfg_en, directed_rows[i].cfg_cnt);
            end else begin
                issue(directed_rows[i]);
            end
        end

        // Fill the rest of the table so any count can be scanned from here on.
        for (int k = 0; k < MAX_ENTRIES; k++) begin
            if (!seg_written[k]) begin
                fill_ent = rand_entry();
                issue(row_write(ENTRY_IDX_W'(k), rand64(), rand64(), fill_ent.len));
            end
        end

        // Random phases; idle mix changes every four phases.
        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            case (ph / 4)
                0: begin
                    snd_idle_pct = 34;
                    rcv_idle_pct = 75;
                end
                1: begin
                    snd_idle_pct = 75;
                    rcv_idle_pct = 34;
                end
                default: begin
                    snd_idle_pct = 0;
                    rcv_idle_pct = 0;
                end
            endcase
            case (ph % 6)
                0: cnt = 5'd16;
                1: cnt = 5'd31;           // above table size: scan stops at 16
                2: cnt = CNT_W'($urandom_range(1, 15));
                3: cnt = 5'd1;
                4: cnt = 5'd0;
                default: cnt = CNT_W'($urandom_range(2, 16));
            endcase
            program_regs((ph % 4) != 2, cnt);
            repeat (ITEMS_PER_PHASE) issue(random_row());
        end

        settle();

        $display("checked %0d translations (%0d expected faults) and %0d table writes",
                 n_checked, n_faulted, n_writes);
        $display("register settings: %0d, idle mixes: sender-heavy, receiver-heavy, none",
                 n_settings);
        if (n_mismatch == 0 && xlate_expect_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches, %0d results missing", n_mismatch, xlate_expect_q.size());
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
